>>> rtl/iepp_pkg.sv
// ============================================================================
// iepp_pkg
// Shared types and constants for the ICMP error probe parser.
// ============================================================================
`default_nettype none

package iepp_pkg;

    // Default width of the packet byte counter
    localparam int COUNT_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_PROBE_SRC   = 2'd0;
    localparam logic [1:0] CFG_BASE_DST    = 2'd1;
    localparam logic [1:0] CFG_HIGHEST_HOP = 2'd2;

    // Configuration reset values
    localparam logic [15:0] PROBE_SRC_RST   = 16'h5053;
    localparam logic [15:0] BASE_DST_RST    = 16'd33434;
    localparam logic [7:0]  HIGHEST_HOP_RST = 8'd30;

    // Message type/code pairs (type in high byte)
    localparam logic [15:0] TC_V4_TIME_EXC = 16'h0B00;
    localparam logic [15:0] TC_V4_PORT_UNR = 16'h0303;
    localparam logic [15:0] TC_V6_TIME_EXC = 16'h0300;
    localparam logic [15:0] TC_V6_PORT_UNR = 16'h0104;

    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Packet layout
    localparam int V6_OUTER_LEN = 40;
    localparam logic [3:0] IP_VER_6 = 4'd6;

    // Length thresholds (length is clamped to 8 bits; all limits are well below)
    localparam logic [7:0] LEN_CLAMP      = 8'd255;
    localparam logic [7:0] V4_MIN_OUTER   = 8'd20;
    localparam logic [7:0] V4_MIN_INNER   = 8'd36;
    localparam logic [7:0] V4_UDP_HDR_MIN = 8'd16;
    localparam logic [7:0] V6_MIN_INNER   = 8'd56;

    // Output stream widths
    localparam int OUT_TDATA_W = 184;
    localparam int OUT_TUSER_W = 2;

    typedef struct packed {
        logic [15:0] probe_src;
        logic [15:0] base_dst;
        logic [7:0]  highest_hop;
    } iepp_cfg_t;

    // State of one packet taken at its last byte
    typedef struct packed {
        logic             is_ipv6;
        logic [7:0]       length;       // packet length, clamped at 255
        logic [7:0]       outer_first;
        logic [5:0]       inner_hlen;
        logic [1:0][15:0] type_code;
        logic [1:0][7:0]  protocol;
        logic [1:0][31:0] ports;        // source port in high half
        logic [1:0][63:0] src_addr;
    } iepp_snap_t;

    typedef struct packed {
        logic        valid_res;
        logic        time_exceeded;
        logic [15:0] inner_source_port;
        logic [15:0] inner_destination_port;
        logic [15:0] hop_number;
        logic        probe_match;
        logic        responder_known;
        logic [63:0] responder_high;
        logic [63:0] responder_low;
    } iepp_result_t;

endpackage

`default_nettype wire

>>> rtl/iepp_capture.sv
// ============================================================================
// iepp_capture
// Input beat register, per-packet byte tracking and end-of-packet snapshot.
// ============================================================================
`default_nettype none

module iepp_capture #(
    parameter int COUNT_BITS = iepp_pkg::COUNT_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_byte,
    input  wire logic               s_is_ipv6,
    input  wire logic               s_last,
    output logic                    snap_valid,
    input  wire logic               snap_ready,
    output iepp_pkg::iepp_snap_t    snap
);
    import iepp_pkg::*;

    localparam int W = COUNT_BITS;

    // Input beat register
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_v6_reg;
    logic         in_last_reg;

    // Packet state
    logic [W-1:0]     cnt_reg, cnt_next;
    logic [7:0]       ofb_reg, ofb_next;
    logic [5:0]       ihl_reg, ihl_next;
    logic [1:0][15:0] tc_reg, tc_next;
    logic [1:0][7:0]  proto_reg, proto_next;
    logic [1:0][31:0] ports_reg, ports_next;
    logic [1:0][63:0] sa_reg, sa_next;

    logic         snap_valid_reg;
    iepp_snap_t   snap_reg, snap_next;

    logic         step;
    logic [W-1:0] p;
    logic [W-1:0] hl;
    logic [W-1:0] port_lo;
    logic [W-1:0] slot_base;
    logic [7:0]   len_clamped;

    // A non-last byte always moves on; a last byte needs room in the snapshot
    assign step    = in_valid_reg && (!in_last_reg || !snap_valid_reg || snap_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            in_byte_reg <= s_byte;
            in_v6_reg   <= s_is_ipv6;
            in_last_reg <= s_last;
        end
    end

    // Field capture for the current byte
    always_comb
    begin
        p          = cnt_reg;
        ofb_next   = (p == '0) ? in_byte_reg : ofb_reg;
        hl         = {{(W-6){1'b0}}, ofb_next[3:0], 2'b00};
        ihl_next   = ihl_reg;
        tc_next    = tc_reg;
        proto_next = proto_reg;
        ports_next = ports_reg;
        sa_next    = sa_reg;
        port_lo    = '0;
        slot_base  = '0;

        if (!in_v6_reg)
        begin
            if (p == hl + W'(8))
            begin
                ihl_next = {in_byte_reg[3:0], 2'b00};
            end
            if (p == hl)
            begin
                tc_next[0][15:8] = in_byte_reg;
            end
            if (p == hl + W'(1))
            begin
                tc_next[0][7:0] = in_byte_reg;
            end
            if (p == hl + W'(17))
            begin
                proto_next[0] = in_byte_reg;
            end
            port_lo = hl + {{(W-6){1'b0}}, ihl_next} + W'(8);
            if (p >= port_lo && p < port_lo + W'(4))
            begin
                ports_next[0] = {ports_reg[0][23:0], in_byte_reg};
            end
            if (p >= W'(12) && p < W'(16))
            begin
                sa_next[1] = {32'b0, sa_reg[1][23:0], in_byte_reg};
            end
        end
        else
        begin
            // Slot 0: no outer header, slot 1: after the 40-byte outer header
            for (int k = 0; k < 2; k++)
            begin
                slot_base = W'(k * V6_OUTER_LEN);
                if (p == slot_base)
                begin
                    tc_next[k][15:8] = in_byte_reg;
                end
                if (p == slot_base + W'(1))
                begin
                    tc_next[k][7:0] = in_byte_reg;
                end
                if (p == slot_base + W'(14))
                begin
                    proto_next[k] = in_byte_reg;
                end
                if (p >= slot_base + W'(48) && p < slot_base + W'(52))
                begin
                    ports_next[k] = {ports_reg[k][23:0], in_byte_reg};
                end
            end
            if (p >= W'(8) && p < W'(16))
            begin
                sa_next[0] = {sa_reg[0][55:0], in_byte_reg};
            end
            if (p >= W'(16) && p < W'(24))
            begin
                sa_next[1] = {sa_reg[1][55:0], in_byte_reg};
            end
        end

        // Saturating byte counter
        cnt_next = (p != '1) ? p + W'(1) : p;

        // Length = p + 1, clamped to 8 bits
        if (p >= W'(LEN_CLAMP))
        begin
            len_clamped = LEN_CLAMP;
        end
        else
        begin
            len_clamped = p[7:0] + 8'd1;
        end

        snap_next.is_ipv6     = in_v6_reg;
        snap_next.length      = len_clamped;
        snap_next.outer_first = ofb_next;
        snap_next.inner_hlen  = ihl_next;
        snap_next.type_code   = tc_next;
        snap_next.protocol    = proto_next;
        snap_next.ports       = ports_next;
        snap_next.src_addr    = sa_next;
    end

    // Packet state registers, cleared after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ofb_reg   <= '0;
            ihl_reg   <= '0;
            tc_reg    <= '0;
            proto_reg <= '0;
            ports_reg <= '0;
            sa_reg    <= '0;
        end
        else if (step)
        begin
            if (in_last_reg)
            begin
                cnt_reg   <= '0;
                ofb_reg   <= '0;
                ihl_reg   <= '0;
                tc_reg    <= '0;
                proto_reg <= '0;
                ports_reg <= '0;
                sa_reg    <= '0;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                ofb_reg   <= ofb_next;
                ihl_reg   <= ihl_next;
                tc_reg    <= tc_next;
                proto_reg <= proto_next;
                ports_reg <= ports_next;
                sa_reg    <= sa_next;
            end
        end
    end

    // Snapshot stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (step && in_last_reg)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

>>> rtl/iepp_decode.sv
// ============================================================================
// iepp_decode
// Classifies a packet snapshot and forms the result item.
// ============================================================================
`default_nettype none

module iepp_decode (
    input  iepp_pkg::iepp_snap_t    snap,
    input  iepp_pkg::iepp_cfg_t     cfg,
    output iepp_pkg::iepp_result_t  result
);
    import iepp_pkg::*;

    logic [7:0]  len;
    logic [7:0]  hl;
    logic [7:0]  il;
    logic        alt;
    logic        slot;
    logic [15:0] tc;
    logic [31:0] ports;
    logic        valid;
    logic        te;
    logic        known;
    logic [15:0] sp;
    logic [15:0] dp;
    logic        dp_ge;
    logic [15:0] hop;
    logic        match;

    always_comb
    begin
        len   = snap.length;
        hl    = {2'b00, snap.outer_first[3:0], 2'b00};
        alt   = 1'b0;
        slot  = 1'b0;
        il    = '0;
        valid = 1'b0;
        te    = 1'b0;
        known = 1'b0;
        result.responder_high = '0;
        result.responder_low  = '0;

        if (!snap.is_ipv6)
        begin
            // IPv4: outer header length taken from its IHL nibble
            tc = snap.type_code[0];
            il = len - hl;
            if (len >= V4_MIN_OUTER && hl <= len)
            begin
                known = 1'b1;
                result.responder_low = {32'b0, snap.src_addr[1][31:0]};
                te    = (tc == TC_V4_TIME_EXC);
                valid = (te || tc == TC_V4_PORT_UNR) && il >= V4_MIN_INNER &&
                        (V4_UDP_HDR_MIN + {2'b00, snap.inner_hlen}) <= il &&
                        snap.protocol[0] == PROTO_UDP;
            end
        end
        else
        begin
            // IPv6: choose the alignment with or without the outer header
            alt  = len >= 8'(V6_OUTER_LEN) && snap.outer_first[7:4] == IP_VER_6;
            slot = alt;
            il   = alt ? len - 8'(V6_OUTER_LEN) : len;
            tc   = snap.type_code[slot];
            if (alt)
            begin
                known = 1'b1;
                result.responder_high = snap.src_addr[0];
                result.responder_low  = snap.src_addr[1];
            end
            te    = (tc == TC_V6_TIME_EXC);
            valid = (te || tc == TC_V6_PORT_UNR) && il >= V6_MIN_INNER &&
                    snap.protocol[slot] == PROTO_UDP;
        end

        // Ports, hop decode and probe check
        ports = snap.ports[slot];
        sp    = ports[31:16];
        dp    = ports[15:0];
        dp_ge = dp >= cfg.base_dst;
        hop   = dp_ge ? dp - cfg.base_dst : 16'd0;
        match = sp == cfg.probe_src && dp_ge && hop != 16'd0 &&
                hop <= {8'b0, cfg.highest_hop};

        result.valid_res              = valid;
        result.time_exceeded          = valid && te;
        result.inner_source_port      = valid ? sp : 16'd0;
        result.inner_destination_port = valid ? dp : 16'd0;
        result.hop_number             = valid ? hop : 16'd0;
        result.probe_match            = valid && match;
        result.responder_known        = known;
    end

endmodule

`default_nettype wire

>>> rtl/icmp_error_probe_parser.sv
// ============================================================================
// icmp_error_probe_parser
// Parses ICMP / ICMPv6 error replies to UDP probes and reports one result
// per packet.
// ============================================================================
// Usage:
//   s_axis: one packet byte per beat; tdata = byte, tuser = 1 for ICMPv6,
//   tlast marks the final byte. Bytes are taken one per cycle while no last
//   byte is held by a stall; packets may follow back to back.
//   m_axis: one result beat per packet, issued for its last byte; tuser
//   carries the valid and time-exceeded flags, tdata ports, hop, match and
//   responder address.
//   cfg: index/data writes of probe source port, base destination port and
//   highest hop; always ready, to be written while the block is idle.
//   Path: the last byte passes the input register, snapshot register and
//   result register before its result is visible.
//   Throughput: one byte per cycle unless a last byte is held by a stall;
//   the byte counter and position compares are the only per-byte work.
//   Reset: configuration returns to its defaults and packet state is cleared.
//   Stall: with m_axis_tready low the result and the snapshot hold; non-last
//   bytes keep flowing, a further last byte waits until a stage frees up.
// ============================================================================
`default_nettype none

module icmp_error_probe_parser #(
    parameter int COUNT_BITS = iepp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Packet bytes
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
    input  wire logic                               s_axis_tuser,  // [0] is_ipv6
    input  wire logic                               s_axis_tlast,  // last_byte
    // Results
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [15:0] inner_source_port, [31:16] inner_destination_port,
    // [47:32] hop_number, [48] probe_match, [49] responder_known,
    // [113:50] responder_high, [177:114] responder_low, [183:178] zero
    output logic [iepp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // [0] valid_res, [1] time_exceeded
    output logic [iepp_pkg::OUT_TUSER_W-1:0]        m_axis_tuser,
    // Configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [15:0]                        cfg_data
);
    import iepp_pkg::*;

    iepp_cfg_t    cfg_reg;
    logic         snap_valid;
    logic         snap_ready;
    iepp_snap_t   snap;
    iepp_result_t result_next;
    iepp_result_t result_reg;
    logic         out_valid_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.probe_src   <= PROBE_SRC_RST;
            cfg_reg.base_dst    <= BASE_DST_RST;
            cfg_reg.highest_hop <= HIGHEST_HOP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PROBE_SRC:   cfg_reg.probe_src   <= cfg_data;
                CFG_BASE_DST:    cfg_reg.base_dst    <= cfg_data;
                CFG_HIGHEST_HOP: cfg_reg.highest_hop <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    iepp_capture #(
        .COUNT_BITS (COUNT_BITS)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_byte     (s_axis_tdata),
        .s_is_ipv6  (s_axis_tuser),
        .s_last     (s_axis_tlast),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    iepp_decode u_decode (
        .snap   (snap),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    // Result register
    assign snap_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            out_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {result_reg.time_exceeded, result_reg.valid_res};
    assign m_axis_tdata  = {6'b0,
                            result_reg.responder_low,
                            result_reg.responder_high,
                            result_reg.responder_known,
                            result_reg.probe_match,
                            result_reg.hop_number,
                            result_reg.inner_destination_port,
                            result_reg.inner_source_port};

    // Checks
    a_match_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.probe_match |-> result_reg.valid_res)
        else $error("probe match on invalid reply");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.valid_res |->
            result_reg.hop_number == 16'd0 && !result_reg.time_exceeded &&
            result_reg.inner_destination_port == 16'd0)
        else $error("invalid reply carries fields");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.responder_known |->
            result_reg.responder_high == 64'd0 && result_reg.responder_low == 64'd0)
        else $error("unknown responder carries an address");

    a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && !snap_ready |=> snap_valid && $stable(snap))
        else $error("snapshot lost under stall");

endmodule

`default_nettype wire
